// ===== hdl/mlid_pkg.sv =====
// Shared widths and operand size codes for the 68000 instruction length decoder.
// No dependencies; imported by mlid_decode and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mlid_pkg;

	// opcode word and length result widths
	localparam int unsigned WORD_W = 16;
	localparam int unsigned LEN_W  = 3;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [LEN_W-1:0]  len_t;

	// operand size in bytes, zero when the size field carries code 3
	typedef logic [2:0] opsize_t;

	localparam opsize_t SZ_NONE = 3'd0;
	localparam opsize_t SZ_BYTE = 3'd1;
	localparam opsize_t SZ_WORD = 3'd2;
	localparam opsize_t SZ_LONG = 3'd4;

	// opcode groups taken from bits 15..12
	localparam logic [3:0] GRP_LINE_A = 4'd10;
	localparam logic [3:0] GRP_LINE_F = 4'd15;

	// decoded length with its unassigned-line flag
	typedef struct packed {
		len_t total_words;
		logic unassigned_line;
	} len_res_t;

endpackage

`default_nettype wire

// ===== hdl/mlid_decode.sv =====
// Combinational length decode of one 68000 opcode word.
// Depends on mlid_pkg for widths, size codes and the result struct.
`timescale 1ns / 1ps
`default_nettype none

module mlid_decode (
	input  wire mlid_pkg::word_t opcode_word,
	output mlid_pkg::len_res_t   res
);
	import mlid_pkg::*;

	// extension words of one effective address
	function automatic logic [1:0] ea_words(input logic [5:0] ea, input opsize_t sz);
		logic [1:0] r;
		r = 2'd0;
		if (ea[5:3] == 3'd5 || ea[5:3] == 3'd6) begin
			r = 2'd1;
		end else if (ea[5:3] == 3'd7) begin
			case (ea[2:0])
				3'd0: r = 2'd1;
				3'd1: r = 2'd2;
				3'd2: r = 2'd1;
				3'd3: r = 2'd1;
				3'd4: r = (sz == SZ_LONG) ? 2'd2 : 2'd1;
				default: r = 2'd0;
			endcase
		end
		return r;
	endfunction

	// size field code to bytes
	function automatic opsize_t size_of(input logic [1:0] code);
		opsize_t s;
		case (code)
			2'd0: s = SZ_BYTE;
			2'd1: s = SZ_WORD;
			2'd2: s = SZ_LONG;
			default: s = SZ_NONE;
		endcase
		return s;
	endfunction

	// size from the three-bit opmode field of the arithmetic groups
	function automatic opsize_t opmode_size(input logic [2:0] op);
		opsize_t s;
		case (op)
			3'd0, 3'd4: s = SZ_BYTE;
			3'd1, 3'd3, 3'd5: s = SZ_WORD;
			default: s = SZ_LONG;
		endcase
		return s;
	endfunction

	logic [15:0] w;
	logic [3:0]  grp;
	logic [5:0]  ea;
	logic [5:0]  dst;
	logic [1:0]  sz2;
	opsize_t     sz;
	opsize_t     msz;
	logic [2:0]  m53;
	logic [2:0]  op86;
	logic        b8;
	len_t        n;

	assign w    = opcode_word;
	assign grp  = w[15:12];
	assign ea   = w[5:0];
	assign dst  = {w[8:6], w[11:9]};
	assign sz2  = w[7:6];
	assign sz   = size_of(w[7:6]);
	assign m53  = w[5:3];
	assign op86 = w[8:6];
	assign b8   = w[8];

	// move size per group
	always_comb begin
		case (grp)
			4'd1: msz = SZ_BYTE;
			4'd2: msz = SZ_LONG;
			default: msz = SZ_WORD;
		endcase
	end

	// length by opcode group
	always_comb begin
		n = len_t'(1);
		case (grp)
			4'd0: begin
				if (b8) begin
					if (m53 == 3'd1)
						n = n + len_t'(1);
					else
						n = n + len_t'(ea_words(ea, SZ_BYTE));
				end else if (w[11:9] == 3'd4) begin
					n = n + len_t'(1) + len_t'(ea_words(ea, SZ_BYTE));
				end else begin
					n = n + ((sz == SZ_BYTE || sz == SZ_WORD) ? len_t'(1) : len_t'(2));
					n = n + len_t'(ea_words(ea, sz));
				end
			end
			4'd1, 4'd2, 4'd3: begin
				n = n + len_t'(ea_words(ea, msz)) + len_t'(ea_words(dst, msz));
			end
			4'd4: begin
				case (w[11:8])
					4'd0, 4'd4, 4'd6:
						n = n + len_t'(ea_words(ea, (sz2 == 2'd3) ? SZ_WORD : sz));
					4'd2:
						n = n + len_t'(ea_words(ea, sz));
					4'd8: begin
						if (sz2 == 2'd0)
							n = n + len_t'(ea_words(ea, SZ_BYTE));
						else if (m53 != 3'd0) begin
							if (sz2 == 2'd1)
								n = n + len_t'(ea_words(ea, SZ_LONG));
							else
								n = n + len_t'(1) + len_t'(ea_words(ea,
									(sz2 == 2'd2) ? SZ_WORD : SZ_LONG));
						end
					end
					4'd10:
						n = n + len_t'(ea_words(ea, (sz2 == 2'd3) ? SZ_BYTE : sz));
					4'd12:
						n = n + len_t'(1) + len_t'(ea_words(ea, w[6] ? SZ_LONG : SZ_WORD));
					4'd14: begin
						// trap, link, unlk, move usp, stop and friends
						if (w[7])
							n = n + len_t'(ea_words(ea, SZ_NONE));
						else if (w[6:4] == 3'd5) begin
							if (!w[3])
								n = n + len_t'(1);
						end else if (w[6:4] != 3'd4 && w[6:4] != 3'd6) begin
							if (w[3:0] == 4'd2)
								n = n + len_t'(1);
						end
					end
					default:
						n = n + len_t'(ea_words(ea, w[6] ? SZ_LONG : SZ_WORD));
				endcase
			end
			4'd5: begin
				if (sz2 == 2'd3) begin
					// dbcc carries a displacement word
					if (m53 == 3'd1)
						n = n + len_t'(1);
					else
						n = n + len_t'(ea_words(ea, SZ_BYTE));
				end else begin
					n = n + len_t'(ea_words(ea, sz));
				end
			end
			4'd6: begin
				// word branch displacement when the byte field is zero
				if (w[7:0] == 8'd0)
					n = n + len_t'(1);
			end
			4'd8: begin
				if (w[8:4] != 5'b10000)
					n = n + len_t'(ea_words(ea, (op86 == 3'd7 || op86 == 3'd3) ?
						SZ_WORD : opmode_size(op86)));
			end
			4'd9: begin
				if (!(b8 && w[5:4] == 2'd0 && sz2 != 2'd3))
					n = n + len_t'(ea_words(ea, opmode_size(op86)));
			end
			4'd11: begin
				if (sz2 == 2'd3)
					n = n + len_t'(ea_words(ea, b8 ? SZ_LONG : SZ_WORD));
				else if (!(b8 && m53 == 3'd1))
					n = n + len_t'(ea_words(ea, sz));
			end
			4'd12: begin
				// exg forms and abcd take no extension
				if (!(w[8:3] inside {6'o50, 6'o51, 6'o61}) && w[8:4] != 5'b10000)
					n = n + len_t'(ea_words(ea, (op86 == 3'd7 || op86 == 3'd3) ?
						SZ_WORD : opmode_size(op86)));
			end
			4'd13: begin
				if (!(b8 && w[5:4] == 2'd0)) begin
					if (sz2 == 2'd3)
						n = n + len_t'(ea_words(ea, b8 ? SZ_LONG : SZ_WORD));
					else
						n = n + len_t'(ea_words(ea, sz));
				end
			end
			4'd14: begin
				if (sz2 == 2'd3)
					n = n + len_t'(ea_words(ea, SZ_WORD));
			end
			default: n = len_t'(1);
		endcase
	end

	assign res.total_words     = n;
	assign res.unassigned_line = (grp == GRP_LINE_A) || (grp == GRP_LINE_F);

endmodule

`default_nettype wire

// ===== hdl/m68k_instruction_length_decoder_unit.sv =====
// Top level of the 68000 instruction length decoder: request register, decode, result register.
// Depends on mlid_pkg and mlid_decode.
`timescale 1ns / 1ps
`default_nettype none

// A request is taken on any clock edge where start is high and busy is low, one opcode
// word per cycle with no gaps needed. Its result passes the request register in front of
// the decode and the result register behind it, then appears on total_words and
// unassigned_line with done high for exactly one cycle; the receiver cannot stall it,
// so results must be captured when done is seen. busy is high only while reset is
// asserted and until the first clock edge after it is released.
module m68k_instruction_length_decoder_unit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire mlid_pkg::word_t opcode_word,
	output logic                 done,
	output mlid_pkg::len_t       total_words,
	output logic                 unassigned_line
);
	import mlid_pkg::*;

	logic     busy_q;
	logic     valid_s1;
	word_t    opcode_s1;
	len_res_t dec_res;
	logic     done_q;
	len_res_t res_q;

	// busy only around reset release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b1;
		else
			busy_q <= 1'b0;
	end

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= start && !busy_q;
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q)
			opcode_s1 <= opcode_word;
	end

	mlid_decode u_decode (
		.opcode_word(opcode_s1),
		.res        (dec_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1)
			res_q <= dec_res;
	end

	assign busy            = busy_q;
	assign done            = done_q;
	assign total_words     = res_q.total_words;
	assign unassigned_line = res_q.unassigned_line;

	// every accepted request produces a result through the request and result registers
	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted request produced no result");

	// no result without a pending request in the request register
	a_done_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result without a pending request");

	// delivered length stays in the legal range
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (total_words != 3'd0 && total_words <= 3'd5))
		else $error("length out of range");

	// unassigned lines are always one word long
	a_line_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && unassigned_line) |-> (total_words == 3'd1))
		else $error("unassigned line with extension words");

endmodule

`default_nettype wire
